// File: design/vnd_pkg.sv
// Package for the vector norm / distance unit.
// Holds widths, codes, the queue entry type and the back-end state type.
// No dependencies.
package vnd_pkg;

  localparam int unsigned ValW   = 16;  // Q8.8 element width
  localparam int unsigned MagW   = 17;  // |a - b| width
  localparam int unsigned SumW   = 48;  // running sum width
  localparam int unsigned OutW   = 28;  // result width
  localparam int unsigned KindW  = 2;
  localparam int unsigned RootSteps = SumW / 2;
  localparam int unsigned StepW  = $clog2(RootSteps);
  localparam int unsigned QueueDepth = 4;

  localparam logic [OutW-1:0] OutMax = OutW'(268431360);

  typedef enum logic [KindW-1:0] {
    KIND_L1   = 2'd0,
    KIND_L2   = 2'd1,
    KIND_LINF = 2'd2
  } norm_kind_e;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_ROOT = 1'b1
  } bk_state_e;

  // One finished vector handed from the front end to the back end.
  typedef struct packed {
    logic            root;   // value needs a floor square root
    logic [SumW-1:0] value;
  } entry_t;

endpackage

// File: design/vnd_in_if.sv
// Input channel of the vector norm / distance unit: one element pair per transaction.
// Depends on vnd_pkg.
interface vnd_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [vnd_pkg::ValW-1:0] first_value;
  logic signed [vnd_pkg::ValW-1:0] second_value;
  logic                            last;

  modport source (output valid, first_value, second_value, last, input ready);
  modport sink   (input valid, first_value, second_value, last, output ready);
endinterface

// File: design/vnd_out_if.sv
// Output channel of the vector norm / distance unit: one result per transaction.
// Depends on vnd_pkg.
interface vnd_out_if;
  logic                     valid;
  logic                     ready;
  logic [vnd_pkg::OutW-1:0] norm_value;

  modport source (output valid, norm_value, input ready);
  modport sink   (input valid, norm_value, output ready);
endinterface

// File: design/vector_norm_distance_unit_top.sv
// Vector norm / distance unit, top level. Depends on vnd_pkg, vnd_in_if,
// vnd_out_if, vnd_front, vnd_fifo and vnd_back.
// Throughput: one element transaction per cycle while the queue has room.
// From the last element, an L1 or Linf result goes through the queue to the output
// register; an L2 result also runs the 24-step square root in the back end.
// Reset (asynchronous, active low) clears accumulators, queue, output and sets L1.
module vector_norm_distance_unit_top #(
  parameter int unsigned QUEUE_DEPTH = vnd_pkg::QueueDepth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      norm_kind_we_i,
  input  logic [vnd_pkg::KindW-1:0] norm_kind_wdata_i,
  vnd_in_if.sink                    in_i,
  vnd_out_if.source                 out_o
);

  // The front end streams element pairs into the accumulators. When a
  // transaction carries the last flag, the finished vector (its sum or its
  // maximum, tagged with whether it still needs a root) enters the queue.
  // The queue lets the next vector accumulate while the back end is busy
  // with a square root or waiting for the sink to take its result.
  logic            push, full, pop, empty;
  vnd_pkg::entry_t push_entry, head_entry;

  vnd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .kind_we_i (norm_kind_we_i),
    .kind_i    (norm_kind_wdata_i),
    .in_i      (in_i),
    .full_i    (full),
    .push_o    (push),
    .entry_o   (push_entry)
  );

  vnd_fifo #(
    .Depth (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .entry_o (head_entry)
  );

  // The back end owns the output register, so a result waiting for the sink
  // stops the front end from taking more elements only once the queue is full.
  vnd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .entry_i (head_entry),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// File: design/vnd_front.sv
// Front end: forms |a - b|, accumulates under the current kind and, on the
// last element, pushes one entry into the queue. Depends on vnd_pkg, vnd_in_if.
module vnd_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        kind_we_i,
  input  logic [vnd_pkg::KindW-1:0]   kind_i,
  vnd_in_if.sink                      in_i,
  input  logic                        full_i,
  output logic                        push_o,
  output vnd_pkg::entry_t             entry_o
);

  logic [vnd_pkg::KindW-1:0] kind_q;
  logic [vnd_pkg::SumW-1:0]  sum_q, sum_d;
  logic [vnd_pkg::MagW-1:0]  max_q, max_d;
  logic                      accept;
  logic signed [vnd_pkg::MagW-1:0] diff;
  logic [vnd_pkg::MagW-1:0]  mag;
  logic [2*vnd_pkg::MagW-1:0] sq;
  logic [vnd_pkg::SumW-1:0]  addend;
  logic [vnd_pkg::SumW:0]    sum_wide;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;

  assign diff = vnd_pkg::MagW'(in_i.first_value) - vnd_pkg::MagW'(in_i.second_value);
  assign mag  = diff[vnd_pkg::MagW-1] ? vnd_pkg::MagW'(-diff) : vnd_pkg::MagW'(diff);
  assign sq   = mag * mag;

  always_comb begin
    case (kind_q)
      vnd_pkg::KIND_L1: addend = vnd_pkg::SumW'(mag);
      vnd_pkg::KIND_L2: addend = vnd_pkg::SumW'(sq);
      default:          addend = '0;
    endcase
    // Sum saturates at all ones instead of wrapping.
    sum_wide = {1'b0, sum_q} + {1'b0, addend};
    sum_d    = sum_wide[vnd_pkg::SumW] ? '1 : sum_wide[vnd_pkg::SumW-1:0];
    max_d    = (mag > max_q) ? mag : max_q;
  end

  always_comb begin
    push_o = accept && in_i.last;
    case (kind_q)
      vnd_pkg::KIND_L1: begin
        entry_o.root  = 1'b0;
        entry_o.value = sum_d;
      end
      vnd_pkg::KIND_L2: begin
        entry_o.root  = 1'b1;
        entry_o.value = sum_d;
      end
      default: begin
        entry_o.root  = 1'b0;
        entry_o.value = vnd_pkg::SumW'(max_d);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= vnd_pkg::KIND_L1;
      sum_q  <= '0;
      max_q  <= '0;
    end else begin
      if (kind_we_i) begin
        kind_q <= kind_i;
      end
      if (accept) begin
        if (in_i.last) begin
          sum_q <= '0;
          max_q <= '0;
        end else begin
          sum_q <= sum_d;
          max_q <= max_d;
        end
      end
    end
  end

endmodule

// File: design/vnd_fifo.sv
// Short queue of finished-vector entries between front and back end.
// Depends on vnd_pkg.
module vnd_fifo #(
  parameter int unsigned Depth = vnd_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  vnd_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output vnd_pkg::entry_t entry_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  vnd_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: design/vnd_back.sv
// Back end: takes queue entries, runs the bit-serial floor square root for L2
// and saturates into the output register. Depends on vnd_pkg, vnd_out_if.
module vnd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  vnd_pkg::entry_t entry_i,
  output logic            pop_o,
  vnd_out_if.source       out_o
);

  vnd_pkg::bk_state_e        state_q, state_d;
  logic [vnd_pkg::SumW-1:0]  x_q, x_d, root_q, root_d;
  logic [vnd_pkg::StepW-1:0] step_q;
  logic [vnd_pkg::SumW-1:0]  bit_w, trial;
  logic                      ge, out_free, last_step, load_pass, load_root, advance;
  logic                      out_valid_q;
  logic [vnd_pkg::OutW-1:0]  out_q;
  logic [vnd_pkg::SumW-1:0]  load_val;

  assign out_free  = !out_valid_q || out_o.ready;
  assign last_step = (step_q == '0);

  // One restoring square-root step per cycle, two input bits at a time; the final step waits for a free output.
  assign bit_w  = vnd_pkg::SumW'(1) << {step_q, 1'b0};
  assign trial  = root_q + bit_w;
  assign ge     = (x_q >= trial);
  assign x_d    = ge ? x_q - trial : x_q;
  assign root_d = (root_q >> 1) + (ge ? bit_w : '0);

  always_comb begin
    state_d = state_q;
    case (state_q)
      vnd_pkg::BK_IDLE: begin
        if (!empty_i && out_free && entry_i.root) begin
          state_d = vnd_pkg::BK_ROOT;
        end
      end
      vnd_pkg::BK_ROOT: begin
        if (last_step && out_free) begin
          state_d = vnd_pkg::BK_IDLE;
        end
      end
      default: state_d = vnd_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o     = 1'b0;
    load_pass = 1'b0;
    load_root = 1'b0;
    advance   = 1'b0;
    case (state_q)
      vnd_pkg::BK_IDLE: begin
        pop_o     = !empty_i && out_free;
        load_pass = pop_o && !entry_i.root;
      end
      vnd_pkg::BK_ROOT: begin
        advance   = !last_step || out_free;
        load_root = last_step && out_free;
      end
      default: ;
    endcase
    load_val = load_root ? root_d : entry_i.value;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vnd_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_pass || load_root) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && entry_i.root) begin
      x_q    <= entry_i.value;
      root_q <= '0;
      step_q <= vnd_pkg::StepW'(vnd_pkg::RootSteps - 1);
    end else if (advance) begin
      x_q    <= x_d;
      root_q <= root_d;
      step_q <= step_q - 1'b1;
    end
    if (load_pass || load_root) begin
      out_q <= (load_val > vnd_pkg::SumW'(vnd_pkg::OutMax)) ? vnd_pkg::OutMax
                                                           : load_val[vnd_pkg::OutW-1:0];
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.norm_value = out_q;

endmodule

// File: tb/tb.sv
// Self-checking testbench for vector_norm_distance_unit_top: directed table, then random phases.
// Depends on vnd_pkg, vnd_in_if, vnd_out_if and the unit's RTL; it reads no files.
`timescale 1ns / 1ps

module tb;

  // The spare kind code must behave like the Linf kind.
  localparam logic [vnd_pkg::KindW-1:0] KindSpare = 2'd3;

  localparam int unsigned RandItems  = 1150;
  // The longest path from the last element to its result runs through the 24-step root.
  localparam int unsigned TailCycles = 40;
  // The watchdog limit, in ns, allows several times the slowest correct run.
  localparam longint unsigned LimitNs = 64'd8_000_000;

  // One row of the directed table. A row repeats the same element pair reps times,
  // and last is set only on the final repeat when the row closes a vector.
  // When has_exp is set, exp_norm is the result read straight off the math;
  // otherwise the predictor supplies it.
  typedef struct packed {
    logic [vnd_pkg::KindW-1:0] kind;
    logic signed [15:0]        a;
    logic signed [15:0]        b;
    int unsigned               reps;
    bit                        last;
    bit                        has_exp;
    logic [vnd_pkg::OutW-1:0]  exp_norm;
  } norm_row_t;

  localparam int NumRows = 24;
  localparam norm_row_t DirectedRows [NumRows] = '{
    // L1, relying on the reset value of the kind register.
    '{vnd_pkg::KIND_L1,   16'sd0,      16'sd0,      1,    1'b1, 1'b1, 28'd0},
    '{vnd_pkg::KIND_L1,   16'sh7FFF,   16'sh8000,   1,    1'b1, 1'b1, 28'd65535},
    '{vnd_pkg::KIND_L1,   16'sh8000,   16'sh7FFF,   1,    1'b1, 1'b1, 28'd65535},
    '{vnd_pkg::KIND_L1,   16'sh8000,   16'sh8000,   1,    1'b1, 1'b1, 28'd0},
    '{vnd_pkg::KIND_L1,   16'sh8000,   16'sd0,      1,    1'b1, 1'b1, 28'd32768},
    '{vnd_pkg::KIND_L1,   16'sh0100,   16'sd0,      3,    1'b1, 1'b1, 28'd768},
    // A run of largest differences builds a large L1 sum.
    '{vnd_pkg::KIND_L1,   16'sh7FFF,   16'sh8000,   16,   1'b1, 1'b1, 28'd1048560},
    // Left open, then closed after the kind has changed to L2.
    '{vnd_pkg::KIND_L1,   16'sh0100,   16'sd0,      1,    1'b0, 1'b0, 28'd0},
    '{vnd_pkg::KIND_L2,   16'sh0100,   16'sd0,      1,    1'b1, 1'b0, 28'd0},
    // 3-4-5 triangle in Q8.8.
    '{vnd_pkg::KIND_L2,   16'sh0300,   16'sd0,      1,    1'b0, 1'b0, 28'd0},
    '{vnd_pkg::KIND_L2,   16'sh0400,   16'sd0,      1,    1'b1, 1'b1, 28'h500},
    '{vnd_pkg::KIND_L2,   16'sh7FFF,   16'sh8000,   1,    1'b1, 1'b1, 28'd65535},
    '{vnd_pkg::KIND_L2,   16'sd1,      16'sd0,      2,    1'b1, 1'b0, 28'd0},
    '{vnd_pkg::KIND_L2,   16'sh7FFF,   16'sh8000,   64,   1'b1, 1'b1, 28'd524280},
    // Open under L2; the maximum keeps tracking, so Linf closes with 0x300.
    '{vnd_pkg::KIND_L2,   16'sh0300,   16'sd0,      1,    1'b0, 1'b0, 28'd0},
    '{vnd_pkg::KIND_LINF, 16'sd1,      16'sd0,      1,    1'b1, 1'b0, 28'd0},
    '{vnd_pkg::KIND_LINF, -16'sd512,   16'sd0,      1,    1'b0, 1'b0, 28'd0},
    '{vnd_pkg::KIND_LINF, 16'sh0100,   16'sd0,      1,    1'b0, 1'b0, 28'd0},
    '{vnd_pkg::KIND_LINF, 16'sd0,      16'sh0300,   1,    1'b1, 1'b1, 28'h300},
    '{vnd_pkg::KIND_LINF, 16'sd0,      16'sd0,      1,    1'b1, 1'b1, 28'd0},
    '{vnd_pkg::KIND_LINF, 16'sh8000,   16'sh7FFF,   1,    1'b1, 1'b1, 28'd65535},
    // Spare kind code acts as Linf.
    '{KindSpare,          -16'sd128,   16'sd128,    1,    1'b0, 1'b0, 28'd0},
    '{KindSpare,          16'sd100,    -16'sd100,   1,    1'b1, 1'b1, 28'd256},
    '{KindSpare,          16'sh7FFF,   16'sd0,      1,    1'b1, 1'b1, 28'd32767}
  };

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        norm_kind_we_i;
  logic [vnd_pkg::KindW-1:0]   norm_kind_wdata_i;

  vnd_in_if  elem_if ();
  vnd_out_if norm_if ();

  vector_norm_distance_unit_top i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .norm_kind_we_i    (norm_kind_we_i),
    .norm_kind_wdata_i (norm_kind_wdata_i),
    .in_i              (elem_if),
    .out_o             (norm_if)
  );

  always #6 clk_i = ~clk_i;

  // Predictor state: the kind in force and the two accumulators, as after reset.
  logic [vnd_pkg::KindW-1:0] kind_cur = vnd_pkg::KIND_L1;
  logic [vnd_pkg::SumW-1:0]  sum_acc  = '0;
  logic [vnd_pkg::MagW-1:0]  max_acc  = '0;

  logic [vnd_pkg::OutW-1:0]  expected_norms[$];
  int unsigned               err_cnt     = 0;
  int unsigned               burst_left  = 0;
  int unsigned               rand_elems  = 0;

  // Floor square root built one result bit at a time, from the top bit down.
  function automatic logic [23:0] root_floor(input logic [vnd_pkg::SumW-1:0] x);
    logic [23:0]              r;
    logic [23:0]              t;
    logic [vnd_pkg::SumW-1:0] sq;
    r = '0;
    for (int i = 23; i >= 0; i--) begin
      t  = r | (24'd1 << i);
      sq = 48'(t) * 48'(t);
      if (sq <= x) begin
        r = t;
      end
    end
    return r;
  endfunction

  // Folds one element pair into the accumulators under the current kind.
  // Returns 1 and the norm when the element closes a vector.
  function automatic bit predict_norm(input logic signed [15:0] a, input logic signed [15:0] b,
                                      input bit last, output logic [vnd_pkg::OutW-1:0] norm);
    logic signed [vnd_pkg::MagW-1:0] diff;
    logic [vnd_pkg::MagW-1:0]        mag;
    logic [vnd_pkg::SumW-1:0]        addend;
    logic [vnd_pkg::SumW:0]          total;
    logic [vnd_pkg::SumW-1:0]        pick;
    diff = $signed({a[15], a}) - $signed({b[15], b});
    mag  = diff[vnd_pkg::MagW-1] ? -diff : diff;
    if (mag > max_acc) begin
      max_acc = mag;
    end
    if (kind_cur == vnd_pkg::KIND_L1) begin
      addend = 48'(mag);
    end else if (kind_cur == vnd_pkg::KIND_L2) begin
      addend = 48'(mag) * 48'(mag);
    end else begin
      addend = '0;
    end
    // The sum sticks at all ones rather than wrapping.
    total   = {1'b0, sum_acc} + {1'b0, addend};
    sum_acc = total[vnd_pkg::SumW] ? '1 : total[vnd_pkg::SumW-1:0];
    norm    = '0;
    if (!last) begin
      return 1'b0;
    end
    if (kind_cur == vnd_pkg::KIND_L1) begin
      pick = sum_acc;
    end else if (kind_cur == vnd_pkg::KIND_L2) begin
      pick = 48'(root_floor(sum_acc));
    end else begin
      pick = 48'(max_acc);
    end
    norm    = (pick > 48'(vnd_pkg::OutMax)) ? vnd_pkg::OutMax : pick[vnd_pkg::OutW-1:0];
    sum_acc = '0;
    max_acc = '0;
    return 1'b1;
  endfunction

  // Sender pacing: bursts of random length, some long enough to run without gaps,
  // separated by idle gaps of random length or none. Called at a clock edge before each element.
  task automatic pace();
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 12);
      if (gap != 0) begin
        elem_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  // Offers one element pair and waits for the transaction. Valid stays high afterwards
  // so back-to-back elements follow without a gap; a gap in pace or a drain lowers it.
  task automatic feed(input logic signed [15:0] a, input logic signed [15:0] b, input bit last,
                      input bit has_exp, input logic [vnd_pkg::OutW-1:0] exp_norm);
    logic [vnd_pkg::OutW-1:0] norm;
    pace();
    elem_if.valid        <= 1'b1;
    elem_if.first_value  <= a;
    elem_if.second_value <= b;
    elem_if.last         <= last;
    do @(posedge clk_i); while (!elem_if.ready);
    if (predict_norm(a, b, last, norm)) begin
      expected_norms.push_back(has_exp ? exp_norm : norm);
    end
  endtask

  // Stops the sender until every expected result is back, then lets the back end
  // settle so that a register write cannot land on work still in flight.
  task automatic drain();
    elem_if.valid <= 1'b0;
    while (expected_norms.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  task automatic set_kind(input logic [vnd_pkg::KindW-1:0] kind);
    norm_kind_we_i    <= 1'b1;
    norm_kind_wdata_i <= kind;
    @(posedge clk_i);
    norm_kind_we_i <= 1'b0;
    kind_cur        = kind;
  endtask

  // Element values lean on the extremes and small values; the rest is full-width noise
  // so that every bit of both fields toggles.
  function automatic logic signed [15:0] pick_q88();
    case ($urandom_range(0, 7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sd0;
      3:       return 16'($urandom_range(0, 1023)) - 16'sd512;
      default: return 16'($urandom);
    endcase
  endfunction

  // Receiver: ready follows a rotating 16-bit pattern that is redrawn now and then.
  // Every pattern holds at least one set bit, so no pattern holds ready low for good.
  // Each result transaction is compared with the oldest expected norm.
  initial begin : receiver
    logic [15:0]              stall_pat;
    int unsigned              pat_age;
    logic [vnd_pkg::OutW-1:0] want;
    norm_if.ready <= 1'b0;
    stall_pat = 16'hFFFF;
    pat_age   = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && norm_if.valid && norm_if.ready) begin
        if (expected_norms.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %0d", $time, norm_if.norm_value);
          err_cnt++;
        end else begin
          want = expected_norms.pop_front();
          if (norm_if.norm_value !== want) begin
            $display("%0t: norm_value mismatch, expected %0d, got %0d",
                     $time, want, norm_if.norm_value);
            err_cnt++;
          end
        end
      end
      if (pat_age == 0) begin
        pat_age = $urandom_range(32, 256);
        case ($urandom_range(0, 3))
          0:       stall_pat = 16'hFFFF;
          1:       stall_pat = 16'h0001;
          default: stall_pat = 16'($urandom) | 16'h0001;
        endcase
      end
      pat_age--;
      norm_if.ready <= stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[15:1]};
    end
  end

  // Main sequence: reset, the directed table, then random phases. Each phase drains,
  // writes a random kind and streams vectors; some phases end on an open vector, so
  // the next kind takes over mid-vector.
  initial begin : stimulus
    logic [vnd_pkg::KindW-1:0] kind;
    logic signed [15:0]        a;
    logic signed [15:0]        b;
    int unsigned               phase_len;
    int unsigned               sent;
    int unsigned               vec_len;
    bit                        plain;
    rst_ni               <= 1'b0;
    norm_kind_we_i       <= 1'b0;
    norm_kind_wdata_i    <= vnd_pkg::KIND_L1;
    elem_if.valid        <= 1'b0;
    elem_if.first_value  <= '0;
    elem_if.second_value <= '0;
    elem_if.last         <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NumRows; r++) begin
      if (DirectedRows[r].kind != kind_cur) begin
        drain();
        set_kind(DirectedRows[r].kind);
      end
      for (int unsigned k = 0; k < DirectedRows[r].reps; k++) begin
        feed(DirectedRows[r].a, DirectedRows[r].b,
             DirectedRows[r].last && (k == DirectedRows[r].reps - 1),
             DirectedRows[r].has_exp, DirectedRows[r].exp_norm);
      end
    end

    while (rand_elems < RandItems) begin
      // Draining here also makes the sender wait for every outstanding result.
      drain();
      case ($urandom_range(0, 3))
        0:       kind = vnd_pkg::KIND_L1;
        1:       kind = vnd_pkg::KIND_L2;
        2:       kind = vnd_pkg::KIND_LINF;
        default: kind = KindSpare;
      endcase
      set_kind(kind);
      phase_len = $urandom_range(30, 150);
      sent      = 0;
      while (sent < phase_len) begin
        vec_len = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 200) : $urandom_range(1, 16);
        plain   = ($urandom_range(0, 2) == 0);
        for (int unsigned i = 0; i < vec_len; i++) begin
          a = pick_q88();
          b = plain ? 16'sd0 : pick_q88();
          feed(a, b, i == vec_len - 1, 1'b0, '0);
        end
        sent += vec_len;
      end
      // Now and then leave a vector open across the kind change.
      if ($urandom_range(0, 2) == 0) begin
        vec_len = $urandom_range(1, 5);
        for (int unsigned i = 0; i < vec_len; i++) begin
          feed(pick_q88(), pick_q88(), 1'b0, 1'b0, '0);
        end
        sent += vec_len;
      end
      rand_elems += sent;
    end

    drain();
    if (err_cnt == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  initial begin : watchdog
    #(LimitNs);
    $display("tb: done, errors");
    $finish;
  end

endmodule

// File: vector_norm_distance_unit_top.f
design/vnd_pkg.sv
design/vnd_in_if.sv
design/vnd_out_if.sv
design/vnd_front.sv
design/vnd_fifo.sv
design/vnd_back.sv
design/vector_norm_distance_unit_top.sv
tb/tb.sv
